// ===== design/fcpa_pkg.sv =====
package fcpa_pkg;

	typedef enum logic [1:0] {
		ACT_SETUP   = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_ALLOC   = 2'd2,
		ACT_FREE    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ALREADY   = 3'd1,
		ST_NOT_SETUP = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_BAD_INDEX = 3'd4
	} status_t;

	typedef enum logic {
		CFG_CHUNK_COUNT = 1'b0,
		CFG_CHUNK_SIZE  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] chunk_index;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  granted_index;
		logic [19:0] byte_offset;
		logic [8:0]  free_chunks;
	} res_t;

	// end-of-list marker for the free head and the links
	localparam logic [8:0] LINK_NONE = 9'd256;

	localparam logic [8:0]  COUNT_RESET = 9'd256;
	localparam logic [12:0] SIZE_RESET  = 13'd16;

endpackage

// ===== design/fcpa_ram.sv =====
module fcpa_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/fixed_chunk_pool_allocator.sv =====
// channel   direction  handshake                 payload
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
// command   in         start while busy is low   cmd (cmd_t)
// result    out        done, one cycle           result (res_t)
//
// the edge that takes an item reads the link memory at the free head; the edge
// that ends busy applies the action and registers the result.
// done is high in the cycle after that, and a new item can be taken then.
// link memory contents are not cleared; reset clears the pool state at once.
// the receiver cannot stall; cfg_ready is always high.
module fixed_chunk_pool_allocator
	import fcpa_pkg::*;
#(
	parameter int MAX_CHUNKS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	output logic        done,
	output res_t        result
);

	localparam int DEPTH = (MAX_CHUNKS < 256) ? MAX_CHUNKS : 256;
	localparam int AW = $clog2(DEPTH);
	localparam logic [8:0] LIMIT = 9'(DEPTH);

	logic [8:0]  chunk_count_q;
	logic [12:0] chunk_size_q;
	logic [8:0]  held_count_q, held_count_d;
	logic [12:0] held_size_q, held_size_d;
	logic [8:0]  free_head_q, free_head_d;
	logic [8:0]  bump_next_q, bump_next_d;
	logic [8:0]  free_total_q, free_total_d;
	logic        active_q, active_d;

	logic        busy_q;
	logic        done_q;
	action_t     act_s1;
	logic [7:0]  idx_s1;
	res_t        res_q, res_d;

	logic        accept;
	logic        link_we;
	logic [8:0]  link_rdata;
	logic [8:0]  eff_count;
	logic [7:0]  granted;
	logic [20:0] product;

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	assign done      = done_q;
	assign result    = res_q;
	assign cfg_ready = 1'b1;

	fcpa_ram #(
		.WIDTH(9),
		.DEPTH(DEPTH)
	) u_link (
		.clk  (clk),
		.we   (link_we),
		.waddr(idx_s1[AW-1:0]),
		.wdata(free_head_q),
		.re   (accept),
		.raddr(free_head_q[AW-1:0]),
		.rdata(link_rdata)
	);

	always_comb begin
		eff_count = chunk_count_q;
		if (eff_count == 9'd0) begin
			eff_count = 9'd1;
		end
		if (eff_count > LIMIT) begin
			eff_count = LIMIT;
		end
	end

	always_comb begin
		held_count_d = held_count_q;
		held_size_d  = held_size_q;
		free_head_d  = free_head_q;
		bump_next_d  = bump_next_q;
		free_total_d = free_total_q;
		active_d     = active_q;
		link_we      = 1'b0;
		granted      = 8'd0;
		res_d.status = ST_OK;

		case (act_s1)
			ACT_SETUP: begin
				if (active_q) begin
					res_d.status = ST_ALREADY;
				end else begin
					held_count_d = eff_count;
					held_size_d  = chunk_size_q;
					free_head_d  = LINK_NONE;
					bump_next_d  = 9'd0;
					free_total_d = eff_count;
					active_d     = 1'b1;
				end
			end
			ACT_RELEASE: begin
				if (!active_q) begin
					res_d.status = ST_NOT_SETUP;
				end else begin
					active_d     = 1'b0;
					free_head_d  = LINK_NONE;
					bump_next_d  = 9'd0;
					free_total_d = 9'd0;
				end
			end
			ACT_ALLOC: begin
				if (!active_q) begin
					res_d.status = ST_NOT_SETUP;
				end else if (free_head_q < held_count_q) begin
					granted     = free_head_q[7:0];
					free_head_d = link_rdata;
				end else if (bump_next_q < held_count_q) begin
					granted     = bump_next_q[7:0];
					bump_next_d = bump_next_q + 9'd1;
				end else begin
					res_d.status = ST_EMPTY;
				end
				if (active_q && res_d.status == ST_OK && free_total_q != 9'd0) begin
					free_total_d = free_total_q - 9'd1;
				end
			end
			ACT_FREE: begin
				if (!active_q) begin
					res_d.status = ST_NOT_SETUP;
				end else if ({1'b0, idx_s1} >= held_count_q) begin
					res_d.status = ST_BAD_INDEX;
				end else begin
					link_we     = 1'b1;
					free_head_d = {1'b0, idx_s1};
					if (free_total_q < held_count_q) begin
						free_total_d = free_total_q + 9'd1;
					end
				end
			end
			default: begin
				res_d.status = ST_NOT_SETUP;
			end
		endcase

		link_we = link_we && busy_q;
		product = 21'(granted) * 21'(held_size_q);
		res_d.granted_index = granted;
		res_d.byte_offset   = product[19:0];
		res_d.free_chunks   = free_total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_count_q <= COUNT_RESET;
			chunk_size_q  <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CHUNK_COUNT: chunk_count_q <= cfg_data[8:0];
				CFG_CHUNK_SIZE:  chunk_size_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			done_q       <= 1'b0;
			held_count_q <= 9'd0;
			held_size_q  <= 13'd0;
			free_head_q  <= LINK_NONE;
			bump_next_q  <= 9'd0;
			free_total_q <= 9'd0;
			active_q     <= 1'b0;
		end else begin
			done_q <= busy_q;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q       <= 1'b0;
				held_count_q <= held_count_d;
				held_size_q  <= held_size_d;
				free_head_q  <= free_head_d;
				bump_next_q  <= bump_next_d;
				free_total_q <= free_total_d;
				active_q     <= active_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1 <= cmd.action;
			idx_s1 <= cmd.chunk_index;
		end
		if (busy_q) begin
			res_q <= res_d;
		end
	end

	a_two_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && !done_q ##1 done_q)
		else $error("result not delivered two cycles after the item");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_total_q <= held_count_q)
		else $error("free count above pool size");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> free_total_q == 9'd0 && free_head_q == LINK_NONE && bump_next_q == 9'd0)
		else $error("released pool holds state");

	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && act_s1 == ACT_ALLOC && res_q.status == ST_OK
			|-> {1'b0, res_q.granted_index} < held_count_q)
		else $error("granted chunk outside pool");

endmodule
